// ===== hdl/acr_pkg.sv =====
// Shared types and constants for the AABB collision resolver.
`timescale 1ns / 1ps

package acr_pkg;

    // Field widths
    localparam int POS_W  = 32;   // signed Q24.8 position and velocity
    localparam int SIZE_W = 24;   // unsigned Q16.8 size
    localparam int ID_W   = 16;
    localparam int KIND_W = 8;

    // Stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = 200;
    localparam int OUT_FIELD_W = 4 * POS_W + 4 + ID_W + KIND_W;
    localparam int OUT_TDATA_W = 160;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Edge coordinates carry two guard bits above the position
    localparam int EDGE_W = POS_W + 2;

    // Request kinds
    typedef enum logic {
        REQ_BEGIN    = 1'b0,
        REQ_PLATFORM = 1'b1
    } req_type_t;

    // One registered input item
    typedef struct packed {
        req_type_t                  req_type;
        logic signed [POS_W-1:0]    pos_x;
        logic signed [POS_W-1:0]    pos_y;
        logic        [SIZE_W-1:0]   size_w;
        logic        [SIZE_W-1:0]   size_h;
        logic signed [POS_W-1:0]    vel_x;
        logic signed [POS_W-1:0]    vel_y;
        logic        [ID_W-1:0]     platform_id;
        logic        [KIND_W-1:0]   platform_kind;
        logic                       last;
    } item_t;

    // Side flags, plus y in the lowest bit
    typedef struct packed {
        logic neg_x;
        logic pos_x;
        logic neg_y;
        logic pos_y;
    } side_flags_t;

    // Outcome of one platform test
    typedef struct packed {
        logic                    hit;
        logic                    axis_x;    // 1: resolve along x, 0: along y
        logic                    push_neg;  // push toward minus
        logic signed [POS_W-1:0] new_pos;   // saturated pushed position on that axis
    } resolve_t;

endpackage

// ===== hdl/aabb_collision_resolver.sv =====
// Top level of the AABB collision resolver: box state, result register and stream ports.
`timescale 1ns / 1ps

// A begin transfer (tuser 0) loads the moving box and clears the side flags; each
// platform transfer (tuser 1) is tested for strict overlap against the box as last
// corrected and, on a hit, pushes the box out along the axis of smaller overlap,
// zeroes that velocity and latches the side flag, platform id and kind. Every input
// transfer yields exactly one output transfer. The block takes one transfer per
// clock while the result side accepts, passing each through the input register and
// the result register; the rate is set by the box state loop, which closes through
// the overlap, axis select and saturating push logic between the input register and
// the box state registers. Positions and velocities are signed Q24.8, sizes unsigned
// Q16.8; pushed positions saturate to the 32-bit range.
module aabb_collision_resolver
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pos_x[31:0], pos_y[63:32], size_w[87:64], size_h[111:88], vel_x[143:112],
    // vel_y[175:144], platform_id[191:176], platform_kind[199:192]
    input  logic [acr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // req_type
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_x[31:0], out_y[63:32], out_vx[95:64], out_vy[127:96], side_pos_y[128],
    // side_neg_y[129], side_pos_x[130], side_neg_x[131], hit_id[147:132],
    // hit_kind[155:148], zero pad[159:156]
    output logic [acr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // hit
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    import acr_pkg::*;

    item_t                  item;
    logic                   item_valid;
    logic                   advance;
    resolve_t               res;

    // Box state
    logic signed [POS_W-1:0]  box_x_reg, box_x_next;
    logic signed [POS_W-1:0]  box_y_reg, box_y_next;
    logic        [SIZE_W-1:0] box_w_reg, box_w_next;
    logic        [SIZE_W-1:0] box_h_reg, box_h_next;
    logic signed [POS_W-1:0]  box_vx_reg, box_vx_next;
    logic signed [POS_W-1:0]  box_vy_reg, box_vy_next;
    side_flags_t              side_flags_reg, side_flags_next;
    logic        [ID_W-1:0]   hit_id_reg, hit_id_next;
    logic        [KIND_W-1:0] hit_kind_reg, hit_kind_next;
    logic                     hit_now;

    // Result register
    logic                     out_valid_reg, out_valid_next;
    logic                     out_hit_reg;
    logic                     out_last_reg;
    logic signed [POS_W-1:0]  out_x_reg, out_y_reg, out_vx_reg, out_vy_reg;
    side_flags_t              out_flags_reg;
    logic        [ID_W-1:0]   out_id_reg;
    logic        [KIND_W-1:0] out_kind_reg;

    acr_input_stage u_input
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    acr_resolve u_resolve
    (
        .item  (item),
        .box_x (box_x_reg),
        .box_y (box_y_reg),
        .box_w (box_w_reg),
        .box_h (box_h_reg),
        .res   (res)
    );

    // Move the held item into the result register when that register frees up
    assign advance = item_valid && (!out_valid_reg || m_axis_tready);

    // Next box state
    always_comb
    begin
        box_x_next      = box_x_reg;
        box_y_next      = box_y_reg;
        box_w_next      = box_w_reg;
        box_h_next      = box_h_reg;
        box_vx_next     = box_vx_reg;
        box_vy_next     = box_vy_reg;
        side_flags_next = side_flags_reg;
        hit_id_next     = hit_id_reg;
        hit_kind_next   = hit_kind_reg;
        hit_now         = 1'b0;
        if (advance)
        begin
            case (item.req_type)
                REQ_BEGIN:
                begin
                    box_x_next      = item.pos_x;
                    box_y_next      = item.pos_y;
                    box_w_next      = item.size_w;
                    box_h_next      = item.size_h;
                    box_vx_next     = item.vel_x;
                    box_vy_next     = item.vel_y;
                    side_flags_next = '0;
                end
                REQ_PLATFORM:
                begin
                    if (res.hit)
                    begin
                        hit_now         = 1'b1;
                        hit_id_next     = item.platform_id;
                        hit_kind_next   = item.platform_kind;
                        side_flags_next = '0;
                        if (res.axis_x)
                        begin
                            box_x_next            = res.new_pos;
                            box_vx_next           = '0;
                            side_flags_next.neg_x = res.push_neg;
                            side_flags_next.pos_x = !res.push_neg;
                        end
                        else
                        begin
                            box_y_next            = res.new_pos;
                            box_vy_next           = '0;
                            side_flags_next.neg_y = res.push_neg;
                            side_flags_next.pos_y = !res.push_neg;
                        end
                    end
                end
                default:
                begin
                    hit_now = 1'b0;
                end
            endcase
        end
    end

    // Result valid: set on advance, drop when the output transfer completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold box state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg      <= '0;
            box_y_reg      <= '0;
            box_w_reg      <= '0;
            box_h_reg      <= '0;
            box_vx_reg     <= '0;
            box_vy_reg     <= '0;
            side_flags_reg <= '0;
            hit_id_reg     <= '0;
            hit_kind_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            box_x_reg      <= box_x_next;
            box_y_reg      <= box_y_next;
            box_w_reg      <= box_w_next;
            box_h_reg      <= box_h_next;
            box_vx_reg     <= box_vx_next;
            box_vy_reg     <= box_vy_next;
            side_flags_reg <= side_flags_next;
            hit_id_reg     <= hit_id_next;
            hit_kind_reg   <= hit_kind_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_hit_reg   <= hit_now;
            out_last_reg  <= item.last;
            out_x_reg     <= box_x_next;
            out_y_reg     <= box_y_next;
            out_vx_reg    <= box_vx_next;
            out_vy_reg    <= box_vy_next;
            out_flags_reg <= side_flags_next;
            out_id_reg    <= hit_id_next;
            out_kind_reg  <= hit_kind_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_kind_reg, out_id_reg, out_flags_reg,
                            out_vy_reg, out_vx_reg, out_y_reg, out_x_reg};

    // A resolved hit sets exactly one side flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_hit_reg) |-> $onehot(out_flags_reg))
        else $error("hit result without exactly one side flag");

    // The latched flags never name two sides
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(side_flags_reg))
        else $error("more than one side flag latched");

    // A resolved hit zeroes the velocity on its axis
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_hit_reg) |-> (out_vx_reg == '0 || out_vy_reg == '0))
        else $error("hit result with both velocity components nonzero");

    // A begin item clears the side flags
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.req_type == REQ_BEGIN) |=> (side_flags_reg == '0))
        else $error("side flags not cleared by begin item");

endmodule

// ===== hdl/acr_input_stage.sv =====
// Input register of the collision resolver: unpacks and holds one transfer.
`timescale 1ns / 1ps

module acr_input_stage
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pos_x[31:0], pos_y[63:32], size_w[87:64], size_h[111:88], vel_x[143:112],
    // vel_y[175:144], platform_id[191:176], platform_kind[199:192]
    input  logic [acr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // req_type
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,
    input  logic                               advance,
    output logic                               item_valid,
    output acr_pkg::item_t                     item
);
    import acr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  take;

    // Take a new transfer when empty or when the held item moves on
    assign s_axis_tready = !valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    // Unpack the incoming transfer
    always_comb
    begin
        item_next = item_reg;
        if (take)
        begin
            item_next.req_type      = req_type_t'(s_axis_tuser);
            item_next.pos_x         = $signed(s_axis_tdata[31:0]);
            item_next.pos_y         = $signed(s_axis_tdata[63:32]);
            item_next.size_w        = s_axis_tdata[87:64];
            item_next.size_h        = s_axis_tdata[111:88];
            item_next.vel_x         = $signed(s_axis_tdata[143:112]);
            item_next.vel_y         = $signed(s_axis_tdata[175:144]);
            item_next.platform_id   = s_axis_tdata[191:176];
            item_next.platform_kind = s_axis_tdata[199:192];
            item_next.last          = s_axis_tlast;
        end
    end

    // Track occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/acr_resolve.sv =====
// Overlap test and minimum-overlap push-out of the moving box against one platform.
`timescale 1ns / 1ps

module acr_resolve
(
    input  acr_pkg::item_t                      item,
    input  logic signed [acr_pkg::POS_W-1:0]    box_x,
    input  logic signed [acr_pkg::POS_W-1:0]    box_y,
    input  logic        [acr_pkg::SIZE_W-1:0]   box_w,
    input  logic        [acr_pkg::SIZE_W-1:0]   box_h,
    output acr_pkg::resolve_t                   res
);
    import acr_pkg::*;

    logic signed [EDGE_W-1:0]   bl, br, bt, bb;
    logic signed [EDGE_W-1:0]   pl, pr, pt, pb;
    logic signed [EDGE_W-1:0]   il, ir, it, ib;
    logic signed [EDGE_W-1:0]   ext_x, ext_y, ext;
    logic signed [EDGE_W:0]     cbx, cby, cpx, cpy;
    logic signed [EDGE_W+1:0]   dx, dy, adx, ady;
    logic signed [EDGE_W+2:0]   ox, oy;
    logic signed [POS_W-1:0]    base;
    logic signed [POS_W+2:0]    sum;
    logic                       axis_x;
    logic                       push_neg;

    always_comb
    begin
        // Edges of both boxes with guard bits
        bl = {{2{box_x[POS_W-1]}}, box_x};
        bt = {{2{box_y[POS_W-1]}}, box_y};
        br = bl + $signed({{(EDGE_W-SIZE_W){1'b0}}, box_w});
        bb = bt + $signed({{(EDGE_W-SIZE_W){1'b0}}, box_h});
        pl = {{2{item.pos_x[POS_W-1]}}, item.pos_x};
        pt = {{2{item.pos_y[POS_W-1]}}, item.pos_y};
        pr = pl + $signed({{(EDGE_W-SIZE_W){1'b0}}, item.size_w});
        pb = pt + $signed({{(EDGE_W-SIZE_W){1'b0}}, item.size_h});

        // Intersection rectangle
        il = (bl > pl) ? bl : pl;
        ir = (br < pr) ? br : pr;
        it = (bt > pt) ? bt : pt;
        ib = (bb < pb) ? bb : pb;
        ext_x = ir - il;
        ext_y = ib - it;

        // Doubled centres, centre differences and overlaps
        cbx = {bl[EDGE_W-1], bl} + {br[EDGE_W-1], br};
        cby = {bt[EDGE_W-1], bt} + {bb[EDGE_W-1], bb};
        cpx = {pl[EDGE_W-1], pl} + {pr[EDGE_W-1], pr};
        cpy = {pt[EDGE_W-1], pt} + {pb[EDGE_W-1], pb};
        dx  = {cbx[EDGE_W], cbx} - {cpx[EDGE_W], cpx};
        dy  = {cby[EDGE_W], cby} - {cpy[EDGE_W], cpy};
        adx = dx[EDGE_W+1] ? -dx : dx;
        ady = dy[EDGE_W+1] ? -dy : dy;
        ox  = $signed({{(EDGE_W+3-SIZE_W-1){1'b0}},
                       ({1'b0, box_w} + {1'b0, item.size_w})}) - {adx[EDGE_W+1], adx};
        oy  = $signed({{(EDGE_W+3-SIZE_W-1){1'b0}},
                       ({1'b0, box_h} + {1'b0, item.size_h})}) - {ady[EDGE_W+1], ady};

        // Pick the axis of smaller overlap; ties go to y
        axis_x   = ox < oy;
        push_neg = axis_x ? dx[EDGE_W+1] : dy[EDGE_W+1];
        base     = axis_x ? box_x : box_y;
        ext      = axis_x ? ext_x : ext_y;

        // Push away and saturate to the position range
        if (push_neg)
        begin
            sum = {{3{base[POS_W-1]}}, base} - {ext[EDGE_W-1], ext};
        end
        else
        begin
            sum = {{3{base[POS_W-1]}}, base} + {ext[EDGE_W-1], ext};
        end

        res.hit      = (il < ir) && (it < ib);
        res.axis_x   = axis_x;
        res.push_neg = push_neg;
        if (sum[POS_W+2:POS_W-1] == '0 || sum[POS_W+2:POS_W-1] == '1)
        begin
            res.new_pos = sum[POS_W-1:0];
        end
        else if (sum[POS_W+2])
        begin
            res.new_pos = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            res.new_pos = {1'b0, {(POS_W-1){1'b1}}};
        end
    end

endmodule

// ===== sim/tb_aabb_collision_resolver.sv =====
// Self-checking testbench for the AABB collision resolver stream block.
`timescale 1ns / 1ps

module tb_aabb_collision_resolver;

    import acr_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up
    localparam int SETTLE_CYCLES = 8;     // wait after the last result before the next test
    localparam int REPORT_MAX    = 10;
    localparam int LONG_HOLD     = 300;

    // One result transfer: {tuser, tlast, tdata} from the highest bit down
    typedef struct packed {
        logic                    hit;
        logic                    pass_end;
        logic [OUT_PAD_W-1:0]    pad;
        logic [KIND_W-1:0]       kind;
        logic [ID_W-1:0]         id;
        side_flags_t             side;
        logic signed [POS_W-1:0] vy;
        logic signed [POS_W-1:0] vx;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } box_report_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    s_axis_tlast;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tlast;

    // Predicted state of the moving box
    logic signed [POS_W-1:0] mov_x = '0;
    logic signed [POS_W-1:0] mov_y = '0;
    logic signed [POS_W-1:0] mov_vx = '0;
    logic signed [POS_W-1:0] mov_vy = '0;
    logic [SIZE_W-1:0]       mov_w = '0;
    logic [SIZE_W-1:0]       mov_h = '0;
    side_flags_t             side_q = '0;
    logic [ID_W-1:0]         latch_id = '0;
    logic [KIND_W-1:0]       latch_kind = '0;

    box_report_t expected_boxes[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          hold_cycles = 0;
    bit          idle_on = 1'b1;

    aabb_collision_resolver dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp a pushed coordinate to the signed 32-bit range
    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'sh8000_0000;
        return v[POS_W-1:0];
    endfunction

    // Apply one item to the predicted box and return the result it should produce
    function automatic box_report_t resolve_item(input item_t it);
        box_report_t r;
        longint bx, by, bw, bh, px, py, pw, ph;
        longint lft, rgt, top_e, bot_e, dx, dy, ox, oy;
        r = '0;
        if (it.req_type == REQ_BEGIN)
        begin
            mov_x  = it.pos_x;
            mov_y  = it.pos_y;
            mov_w  = it.size_w;
            mov_h  = it.size_h;
            mov_vx = it.vel_x;
            mov_vy = it.vel_y;
            side_q = '0;
        end
        else
        begin
            bx = longint'(mov_x);
            by = longint'(mov_y);
            bw = longint'(mov_w);
            bh = longint'(mov_h);
            px = longint'(it.pos_x);
            py = longint'(it.pos_y);
            pw = longint'(it.size_w);
            ph = longint'(it.size_h);
            lft   = (bx > px) ? bx : px;
            rgt   = (bx + bw < px + pw) ? bx + bw : px + pw;
            top_e = (by > py) ? by : py;
            bot_e = (by + bh < py + ph) ? by + bh : py + ph;
            // strict overlap only; touching or empty boxes pass through
            if (lft < rgt && top_e < bot_e)
            begin
                dx = (2 * bx + bw) - (2 * px + pw);
                dy = (2 * by + bh) - (2 * py + ph);
                ox = (bw + pw) - ((dx < 0) ? -dx : dx);
                oy = (bh + ph) - ((dy < 0) ? -dy : dy);
                r.hit      = 1'b1;
                latch_id   = it.platform_id;
                latch_kind = it.platform_kind;
                side_q     = '0;
                // ties go to y; a zero centre offset pushes toward plus
                if (ox < oy)
                begin
                    if (dx < 0)
                    begin
                        side_q.neg_x = 1'b1;
                        mov_x = clamp_pos(bx - (rgt - lft));
                    end
                    else
                    begin
                        side_q.pos_x = 1'b1;
                        mov_x = clamp_pos(bx + (rgt - lft));
                    end
                    mov_vx = '0;
                end
                else
                begin
                    if (dy < 0)
                    begin
                        side_q.neg_y = 1'b1;
                        mov_y = clamp_pos(by - (bot_e - top_e));
                    end
                    else
                    begin
                        side_q.pos_y = 1'b1;
                        mov_y = clamp_pos(by + (bot_e - top_e));
                    end
                    mov_vy = '0;
                end
            end
        end
        r.pass_end = it.last;
        r.x    = mov_x;
        r.y    = mov_y;
        r.vx   = mov_vx;
        r.vy   = mov_vy;
        r.side = side_q;
        r.id   = latch_id;
        r.kind = latch_kind;
        return r;
    endfunction

    function automatic item_t begin_item(input logic signed [POS_W-1:0] x, y,
                                         input logic [SIZE_W-1:0] w, h,
                                         input logic signed [POS_W-1:0] vx, vy,
                                         input logic lst);
        item_t it;
        it.req_type      = REQ_BEGIN;
        it.pos_x         = x;
        it.pos_y         = y;
        it.size_w        = w;
        it.size_h        = h;
        it.vel_x         = vx;
        it.vel_y         = vy;
        it.platform_id   = ID_W'($urandom);
        it.platform_kind = KIND_W'($urandom);
        it.last          = lst;
        return it;
    endfunction

    function automatic item_t platform_item(input logic signed [POS_W-1:0] x, y,
                                            input logic [SIZE_W-1:0] w, h,
                                            input logic [ID_W-1:0] id,
                                            input logic [KIND_W-1:0] kind,
                                            input logic lst);
        item_t it;
        it.req_type      = REQ_PLATFORM;
        it.pos_x         = x;
        it.pos_y         = y;
        it.size_w        = w;
        it.size_h        = h;
        it.vel_x         = $urandom;
        it.vel_y         = $urandom;
        it.platform_id   = id;
        it.platform_kind = kind;
        it.last          = lst;
        return it;
    endfunction

    // Mostly small boxes, sometimes empty or at full size
    function automatic logic [SIZE_W-1:0] rand_size();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return SIZE_W'($urandom);
            2:       return {SIZE_W{1'b1}};
            default: return SIZE_W'($urandom_range(1, 24'h4000));
        endcase
    endfunction

    // Mostly near the origin, sometimes anywhere in the range
    function automatic logic signed [POS_W-1:0] rand_pos();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endfunction

    // Platform placed around the current corrected box so that most tests hit
    function automatic item_t near_platform(input logic lst);
        longint px, py;
        logic [SIZE_W-1:0] pw, ph;
        pw = rand_size();
        ph = rand_size();
        case ($urandom_range(0, 7))
            0:
            begin
                // touch the right edge
                px = longint'(mov_x) + longint'(mov_w);
                py = longint'(mov_y);
            end
            1:
            begin
                // touch the top edge
                px = longint'(mov_x);
                py = longint'(mov_y) - longint'(ph);
            end
            2:
            begin
                // coincide with the box
                pw = mov_w;
                ph = mov_h;
                px = longint'(mov_x);
                py = longint'(mov_y);
            end
            default:
            begin
                px = longint'(mov_x) - longint'($urandom_range(0, pw))
                     + longint'($urandom_range(0, mov_w));
                py = longint'(mov_y) - longint'($urandom_range(0, ph))
                     + longint'($urandom_range(0, mov_h));
            end
        endcase
        return platform_item(px[POS_W-1:0], py[POS_W-1:0], pw, ph,
                             ID_W'($urandom), KIND_W'($urandom), lst);
    endfunction

    // Drive one item and record its expected result once the transfer is taken
    task automatic send_item(input item_t it);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tdata  <= {it.platform_kind, it.platform_id, it.vel_y, it.vel_x,
                          it.size_h, it.size_w, it.pos_y, it.pos_x};
        s_axis_tuser  <= it.req_type;
        s_axis_tlast  <= it.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        expected_boxes.push_back(resolve_item(it));
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_boxes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_platform_before_begin();
        send_item(platform_item(32'sh0, 32'sh0, {SIZE_W{1'b1}}, {SIZE_W{1'b1}},
                                16'hFFFF, 8'hFF, 1'b1));
        drain_results();
    endtask

    task automatic test_touch_and_zero_size();
        send_item(begin_item(32'sh0, 32'sh0, 24'h1000, 24'h1000,
                             32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0));
        send_item(platform_item(32'sh1000, 32'sh0, 24'h1000, 24'h1000, 16'h0001, 8'h01, 1'b0));
        send_item(platform_item(32'sh0, 32'sh1000, 24'h1000, 24'h1000, 16'h0002, 8'h02, 1'b0));
        send_item(platform_item(32'sh800, 32'sh0, 24'h0, 24'h1000, 16'h0003, 8'h03, 1'b0));
        send_item(begin_item(32'sh0, 32'sh0, 24'h0, 24'h1000, 32'sh0, 32'sh0, 1'b0));
        send_item(platform_item(-32'sh100, 32'sh0, 24'h1000, 24'h1000, 16'h0004, 8'h04, 1'b1));
        drain_results();
    endtask

    task automatic test_axis_select();
        // thin overlap from the left, then from above
        send_item(begin_item(32'sh0, 32'sh0, 24'h1000, 24'h1000, 32'sh100, -32'sh100, 1'b0));
        send_item(platform_item(-32'shF00, 32'sh0, 24'h1000, 24'h1000, 16'h1234, 8'h56, 1'b0));
        send_item(platform_item(32'sh100, -32'shF00, 24'h1000, 24'h1000, 16'h0000, 8'h00, 1'b0));
        // equal overlaps resolve along y
        send_item(begin_item(32'sh0, 32'sh0, 24'h1000, 24'h1000, 32'sh200, 32'sh300, 1'b0));
        send_item(platform_item(32'sh800, 32'sh800, 24'h1000, 24'h1000, 16'hA5A5, 8'h5A, 1'b0));
        // coincident boxes push toward plus y
        send_item(begin_item(32'sh0, 32'sh0, 24'h1000, 24'h1000, 32'sh200, 32'sh300, 1'b0));
        send_item(platform_item(32'sh0, 32'sh0, 24'h1000, 24'h1000, 16'h00FF, 8'hF0, 1'b0));
        // centred on x with the smaller overlap on x pushes toward plus x
        send_item(begin_item(32'sh0, 32'sh0, 24'h1000, 24'h1000, 32'sh200, 32'sh300, 1'b0));
        send_item(platform_item(32'sh400, 32'sh0, 24'h800, 24'h1000, 16'h0F0F, 8'h0F, 1'b1));
        drain_results();
    endtask

    task automatic test_saturation();
        send_item(begin_item(32'sh7FFF_FFF0, 32'sh0, {SIZE_W{1'b1}}, {SIZE_W{1'b1}},
                             32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0));
        send_item(platform_item(32'sh7FFF_0000, 32'sh0, {SIZE_W{1'b1}}, {SIZE_W{1'b1}},
                                16'h1111, 8'h11, 1'b0));
        send_item(begin_item(32'sh8000_0010, 32'sh0, {SIZE_W{1'b1}}, {SIZE_W{1'b1}},
                             32'sh1, -32'sh1, 1'b0));
        send_item(platform_item(32'sh8001_0010, 32'sh0, {SIZE_W{1'b1}}, {SIZE_W{1'b1}},
                                16'h2222, 8'h22, 1'b0));
        send_item(begin_item(32'sh0, 32'sh7FFF_FFF0, {SIZE_W{1'b1}}, {SIZE_W{1'b1}},
                             32'sh1, -32'sh1, 1'b0));
        send_item(platform_item(32'sh0, 32'sh7FFF_0000, {SIZE_W{1'b1}}, {SIZE_W{1'b1}},
                                16'h3333, 8'h33, 1'b1));
        drain_results();
    endtask

    // Passes of a begin and several platforms, with some random noise items
    task automatic test_random_passes(input int n_items);
        item_t noise;
        int    sent;
        int    n_plat;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                noise.req_type      = $urandom_range(0, 1) ? REQ_PLATFORM : REQ_BEGIN;
                noise.pos_x         = $urandom;
                noise.pos_y         = $urandom;
                noise.size_w        = SIZE_W'($urandom);
                noise.size_h        = SIZE_W'($urandom);
                noise.vel_x         = $urandom;
                noise.vel_y         = $urandom;
                noise.platform_id   = ID_W'($urandom);
                noise.platform_kind = KIND_W'($urandom);
                noise.last          = 1'($urandom_range(0, 1));
                send_item(noise);
                sent++;
            end
            else
            begin
                send_item(begin_item(rand_pos(), rand_pos(), rand_size(), rand_size(),
                                     $urandom, $urandom, 1'b0));
                n_plat = $urandom_range(1, 8);
                for (int k = 0; k < n_plat; k++)
                    send_item(near_platform(k == n_plat - 1));
                sent += n_plat + 1;
            end
        end
        drain_results();
    endtask

    // Hold off the result side while items keep coming, so the input stalls
    task automatic test_output_hold();
        hold_cycles = LONG_HOLD;
        test_random_passes(24);
    endtask

    // Result side: random stall bursts and one long hold on request
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                m_axis_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        box_report_t got;
        box_report_t want;
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            got = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
            if (expected_boxes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result at %0t: x=%h y=%h", $realtime, got.x, got.y);
            end
            else
            begin
                want = expected_boxes.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display({"  exp hit=%b x=%h y=%h vx=%h vy=%h side=%b",
                                  " id=%h kind=%h end=%b pad=%h"},
                                 want.hit, want.x, want.y, want.vx, want.vy, want.side,
                                 want.id, want.kind, want.pass_end, want.pad);
                        $display({"  got hit=%b x=%h y=%h vx=%h vy=%h side=%b",
                                  " id=%h kind=%h end=%b pad=%h"},
                                 got.hit, got.x, got.y, got.vx, got.vy, got.side,
                                 got.id, got.kind, got.pass_end, got.pad);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
            || (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Test sequence
    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_platform_before_begin();
        test_touch_and_zero_size();
        test_axis_select();
        test_saturation();
        test_random_passes(400);
        test_output_hold();
        test_random_passes(400);
        idle_on = 1'b0;
        test_random_passes(150);

        if (mismatch_count == 0 && expected_boxes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/acr_pkg.sv
hdl/acr_input_stage.sv
hdl/acr_resolve.sv
hdl/aabb_collision_resolver.sv
sim/tb_aabb_collision_resolver.sv
